FILE: rtl/rso_pkg.sv
// ----------------------------------------------------------------------------
// rso_pkg
// shared types and constants of the reservoir spill outflow core
// ----------------------------------------------------------------------------
package rso_pkg;

    localparam int LAKES_DEF   = 8;
    localparam int ENTRIES_DEF = 16;

    // weir constant sqrt(2g)*sqrt(1/3)*2/3 in q16.16
    localparam logic [16:0] WEIR_K = 17'd111732;

    // shared multiplier widths
    localparam int MUL_A_W = 49;
    localparam int MUL_B_W = 40;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int MUL_D_W = 8;

    // square root of a 32 bit value shifted left by 16
    localparam int SQ_IN_W  = 32;
    localparam int SQ_OUT_W = 24;

    localparam logic [1:0] OP_EVAL  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_COUNT = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQRT,
        S_HMUL,
        S_KMUL,
        S_WMUL,
        S_FMUL,
        S_RD,
        S_WALK,
        S_IMUL,
        S_IDIV,
        S_OUT
    } t_state;

endpackage

FILE: rtl/rso_table.sv
// ----------------------------------------------------------------------------
// rso_table
// rating table memory, stage and flow per entry, one write and one read port
// ----------------------------------------------------------------------------
module rso_table #(
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [63:0]       i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [63:0]       o_rdata
);

    logic [63:0] r_mem [DEPTH];
    logic [63:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/rso_mul.sv
// ----------------------------------------------------------------------------
// rso_mul
// shared multiplier, one 8 bit digit of the b operand per cycle
// ----------------------------------------------------------------------------
module rso_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rso_pkg::MUL_A_W-1:0] i_a,
    input  logic [rso_pkg::MUL_B_W-1:0] i_b,
    output logic                        o_busy,
    output logic                        o_done,
    output logic [rso_pkg::MUL_P_W-1:0] o_p
);

    localparam int AW    = rso_pkg::MUL_A_W;
    localparam int BW    = rso_pkg::MUL_B_W;
    localparam int PW    = rso_pkg::MUL_P_W;
    localparam int DW    = rso_pkg::MUL_D_W;
    localparam int SW    = AW + DW;
    localparam int STEPS = BW / DW;
    localparam int CW    = $clog2(STEPS);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] r_a;
    logic [PW-1:0] r_p;
    logic [SW-1:0] sum;

    assign sum = {{DW{1'b0}}, r_p[PW-1:BW]} + r_a * r_p[DW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (int'(r_cnt) == STEPS - 1);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (int'(r_cnt) == STEPS - 1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_p <= {{AW{1'b0}}, i_b};
        end else if (r_busy) begin
            r_p <= {sum, r_p[BW-1:DW]};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_p    = r_p;

endmodule

FILE: rtl/rso_sqrt.sv
// ----------------------------------------------------------------------------
// rso_sqrt
// digit by digit integer square root of the input shifted left by 16
// ----------------------------------------------------------------------------
module rso_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [rso_pkg::SQ_IN_W-1:0]  i_value,
    output logic                         o_busy,
    output logic                         o_done,
    output logic [rso_pkg::SQ_OUT_W-1:0] o_root
);

    localparam int RW = rso_pkg::SQ_OUT_W;
    localparam int VW = 2 * RW;
    localparam int MW = RW + 2;
    localparam int CW = $clog2(RW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [VW-1:0] r_v;
    logic [MW-1:0] r_rem;
    logic [RW-1:0] r_root;
    logic [MW-1:0] rem2;
    logic [MW-1:0] trial;

    assign rem2  = {r_rem[MW-3:0], r_v[VW-1 -: 2]};
    assign trial = {r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (int'(r_cnt) == RW - 1);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (int'(r_cnt) == RW - 1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v    <= {i_value, {(VW - rso_pkg::SQ_IN_W){1'b0}}};
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_v <= {r_v[VW-3:0], 2'b00};
            if (rem2 >= trial) begin
                r_rem  <= rem2 - trial;
                r_root <= {r_root[RW-2:0], 1'b1};
            end else begin
                r_rem  <= rem2;
                r_root <= {r_root[RW-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_root = r_root;

endmodule

FILE: rtl/rso_div.sv
// ----------------------------------------------------------------------------
// rso_div
// restoring divider, 64 by 32 bits with a quotient known to fit 32 bits
// ----------------------------------------------------------------------------
module rso_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_busy,
    output logic        o_done,
    output logic [31:0] o_quot
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_q;
    logic [31:0] r_den;
    logic [32:0] t;
    logic        ge;

    assign t  = {r_rem, r_q[31]};
    assign ge = t >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 5'd31);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[63:32];
            r_q   <= i_num[31:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? 32'(t - {1'b0, r_den}) : t[31:0];
            r_q   <= {r_q[30:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

FILE: rtl/reservoir_spill_outflow_core.sv
// ----------------------------------------------------------------------------
// reservoir_spill_outflow_core
// weir plus rating table outflow, q16.16, tables held in one memory
//
//   beat    valid        ready        payload
//   in      i_in_valid   o_in_ready   i_operation .. i_drain_open
//   out     o_out_valid  i_out_ready  o_outflow
//
// table and count writes complete while idle; an evaluate with the drain
// open goes straight to output; others run a 24 step square root and four
// 5 digit multiplies if the level is above the crest, one memory read per
// rating entry walked, and a 5 digit multiply plus a 32 step divide to
// interpolate. no clearing pass after reset; counts reset to zero.
// a new beat is taken while a finished result still waits at the output.
// ----------------------------------------------------------------------------
module reservoir_spill_outflow_core #(
    parameter int LAKES   = rso_pkg::LAKES_DEF,
    parameter int ENTRIES = rso_pkg::ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_operation,
    input  logic [2:0]         i_lake_index,
    input  logic [4:0]         i_entry_index,
    input  logic signed [31:0] i_entry_stage,
    input  logic [31:0]        i_entry_flow,
    input  logic signed [31:0] i_lake_level,
    input  logic signed [31:0] i_crest_elev,
    input  logic [31:0]        i_weir_width,
    input  logic [31:0]        i_weir_coef,
    input  logic [31:0]        i_base_flow,
    input  logic               i_drain_open,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [31:0]        o_outflow
);

    localparam int DEPTH  = LAKES * ENTRIES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int K_W    = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int LI_W   = (LAKES > 1) ? $clog2(LAKES) : 1;
    localparam int AW     = rso_pkg::MUL_A_W;
    localparam int BW     = rso_pkg::MUL_B_W;
    localparam int PW     = rso_pkg::MUL_P_W;

    rso_pkg::t_state r_state, n_state;

    logic               r_launch, n_launch;
    logic               r_out_valid, n_out_valid;
    logic [31:0]        r_outflow, n_outflow;
    logic [2:0]         r_lake, n_lake;
    logic signed [31:0] r_level, n_level;
    logic [31:0]        r_h, n_h;
    logic [31:0]        r_width, n_width;
    logic [31:0]        r_coef, n_coef;
    logic [31:0]        r_base, n_base;
    logic [23:0]        r_sq, n_sq;
    logic [39:0]        r_h15, n_h15;
    logic [AW-1:0]      r_acc, n_acc;
    logic [32:0]        r_weir, n_weir;
    logic [31:0]        r_pipe, n_pipe;
    logic [CNT_W-1:0]   r_n, n_n;
    logic [K_W-1:0]     r_k, n_k;
    logic [31:0]        r_ps, n_ps;
    logic [31:0]        r_pf, n_pf;
    logic [31:0]        r_num, n_num;
    logic [31:0]        r_den, n_den;
    logic [31:0]        r_d, n_d;
    logic               r_up, n_up;
    logic [63:0]        r_prod, n_prod;

    logic [CNT_W-1:0]   r_counts [LAKES];

    logic               in_fire;
    logic               in_lake_ok;
    logic signed [32:0] h_diff;
    logic               lake_ok;
    logic [LI_W-1:0]    lake_sel;
    logic [LI_W-1:0]    in_lake_sel;
    logic [CNT_W-1:0]   cnt_cur;
    logic [33:0]        total;

    logic               tbl_we;
    logic [ADDR_W-1:0]  tbl_waddr;
    logic               tbl_re;
    logic [ADDR_W-1:0]  tbl_raddr;
    logic [63:0]        tbl_rdata;
    logic [31:0]        rd_stage;
    logic [31:0]        rd_flow;

    logic               mul_start, mul_busy, mul_done;
    logic [AW-1:0]      mul_a;
    logic [BW-1:0]      mul_b;
    logic [PW-1:0]      mul_p;
    logic               sq_start, sq_busy, sq_done;
    logic [23:0]        sq_root;
    logic               div_start, div_busy, div_done;
    logic [31:0]        div_q;

    assign in_fire     = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == rso_pkg::S_IDLE);
    assign in_lake_ok  = int'(i_lake_index) < LAKES;
    assign in_lake_sel = LI_W'(i_lake_index);
    assign h_diff      = $signed({i_lake_level[31], i_lake_level})
                       - $signed({i_crest_elev[31], i_crest_elev});
    assign lake_ok     = int'(r_lake) < LAKES;
    assign lake_sel    = LI_W'(r_lake);
    assign cnt_cur     = r_counts[lake_sel];
    assign rd_stage    = tbl_rdata[63:32];
    assign rd_flow     = tbl_rdata[31:0];
    assign total       = 34'(r_base) + 34'(r_weir) + 34'(r_pipe);

    assign tbl_we    = in_fire && (i_operation == rso_pkg::OP_WRITE) && in_lake_ok
                       && (int'(i_entry_index) < ENTRIES);
    assign tbl_waddr = ADDR_W'(int'(i_lake_index) * ENTRIES + int'(i_entry_index));

    rso_table #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata ({i_entry_stage, i_entry_flow}),
        .i_re    (tbl_re),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    rso_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_busy  (mul_busy),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    rso_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (r_h),
        .o_busy  (sq_busy),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    rso_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_prod),
        .i_den   (r_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // multiplier operands by step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            rso_pkg::S_HMUL: begin
                mul_a = AW'(r_h);
                mul_b = BW'(r_sq);
            end
            rso_pkg::S_KMUL: begin
                mul_a = AW'(r_coef);
                mul_b = BW'(rso_pkg::WEIR_K);
            end
            rso_pkg::S_WMUL: begin
                mul_a = AW'(r_acc[32:0]);
                mul_b = BW'(r_width);
            end
            rso_pkg::S_FMUL: begin
                mul_a = r_acc;
                mul_b = r_h15;
            end
            rso_pkg::S_IMUL: begin
                mul_a = AW'(r_d);
                mul_b = BW'(r_num);
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_launch    = r_launch;
        n_out_valid = r_out_valid && !i_out_ready;
        n_outflow   = r_outflow;
        n_lake      = r_lake;
        n_level     = r_level;
        n_h         = r_h;
        n_width     = r_width;
        n_coef      = r_coef;
        n_base      = r_base;
        n_sq        = r_sq;
        n_h15       = r_h15;
        n_acc       = r_acc;
        n_weir      = r_weir;
        n_pipe      = r_pipe;
        n_n         = r_n;
        n_k         = r_k;
        n_ps        = r_ps;
        n_pf        = r_pf;
        n_num       = r_num;
        n_den       = r_den;
        n_d         = r_d;
        n_up        = r_up;
        n_prod      = r_prod;
        tbl_re      = 1'b0;
        tbl_raddr   = '0;
        mul_start   = 1'b0;
        sq_start    = 1'b0;
        div_start   = 1'b0;

        unique case (r_state)
            rso_pkg::S_IDLE: begin
                if (in_fire && (i_operation == rso_pkg::OP_EVAL)) begin
                    n_lake  = i_lake_index;
                    n_level = i_lake_level;
                    n_h     = h_diff[31:0];
                    n_width = i_weir_width;
                    n_coef  = i_weir_coef;
                    n_base  = i_base_flow;
                    n_weir  = '0;
                    n_pipe  = '0;
                    if (i_drain_open) begin
                        n_state = rso_pkg::S_OUT;
                    end else if (!h_diff[32] && (|h_diff[31:0])) begin
                        n_state = rso_pkg::S_SQRT;
                    end else begin
                        n_state = rso_pkg::S_RD;
                    end
                end
            end
            rso_pkg::S_SQRT: begin
                sq_start = !r_launch;
                n_launch = 1'b1;
                if (sq_done) begin
                    n_launch = 1'b0;
                    n_sq     = sq_root;
                    n_state  = rso_pkg::S_HMUL;
                end
            end
            rso_pkg::S_HMUL, rso_pkg::S_KMUL, rso_pkg::S_WMUL,
            rso_pkg::S_FMUL, rso_pkg::S_IMUL: begin
                mul_start = !r_launch;
                n_launch  = 1'b1;
                if (mul_done) begin
                    n_launch = 1'b0;
                    unique case (r_state)
                        rso_pkg::S_HMUL: begin
                            n_h15   = mul_p[55:16];
                            n_state = rso_pkg::S_KMUL;
                        end
                        rso_pkg::S_KMUL: begin
                            n_acc   = AW'(mul_p[48:16]);
                            n_state = rso_pkg::S_WMUL;
                        end
                        rso_pkg::S_WMUL: begin
                            n_acc   = mul_p[64:16];
                            n_state = rso_pkg::S_FMUL;
                        end
                        rso_pkg::S_FMUL: begin
                            n_weir  = (|mul_p[PW-1:48]) ? 33'h1_0000_0000
                                                        : {1'b0, mul_p[47:16]};
                            n_state = rso_pkg::S_RD;
                        end
                        default: begin
                            n_prod  = mul_p[63:0];
                            n_state = rso_pkg::S_IDIV;
                        end
                    endcase
                end
            end
            rso_pkg::S_RD: begin
                if (lake_ok && (cnt_cur != '0)) begin
                    tbl_re    = 1'b1;
                    tbl_raddr = ADDR_W'(int'(r_lake) * ENTRIES);
                    n_n       = cnt_cur;
                    n_k       = '0;
                    n_state   = rso_pkg::S_WALK;
                end else begin
                    n_state = rso_pkg::S_OUT;
                end
            end
            rso_pkg::S_WALK: begin
                if ($signed(rd_stage) >= r_level) begin
                    if (r_k == '0) begin
                        n_pipe  = '0;
                        n_state = rso_pkg::S_OUT;
                    end else if ($signed(rd_stage) <= $signed(r_ps)) begin
                        n_pipe  = rd_flow;
                        n_state = rso_pkg::S_OUT;
                    end else begin
                        n_num   = 32'(r_level - $signed(r_ps));
                        n_den   = rd_stage - r_ps;
                        n_up    = rd_flow >= r_pf;
                        n_d     = (rd_flow >= r_pf) ? rd_flow - r_pf : r_pf - rd_flow;
                        n_state = rso_pkg::S_IMUL;
                    end
                end else if (int'(r_k) == int'(r_n) - 1) begin
                    n_pipe  = rd_flow;
                    n_state = rso_pkg::S_OUT;
                end else begin
                    n_ps      = rd_stage;
                    n_pf      = rd_flow;
                    n_k       = r_k + 1'b1;
                    tbl_re    = 1'b1;
                    tbl_raddr = ADDR_W'(int'(r_lake) * ENTRIES + int'(r_k) + 1);
                end
            end
            rso_pkg::S_IDIV: begin
                div_start = !r_launch;
                n_launch  = 1'b1;
                if (div_done) begin
                    n_launch = 1'b0;
                    n_pipe   = r_up ? r_pf + div_q : r_pf - div_q;
                    n_state  = rso_pkg::S_OUT;
                end
            end
            rso_pkg::S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_outflow   = (|total[33:32]) ? 32'hFFFF_FFFF : total[31:0];
                    n_state     = rso_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rso_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rso_pkg::S_IDLE;
            r_launch    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < LAKES; i++) begin
                r_counts[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_launch    <= n_launch;
            r_out_valid <= n_out_valid;
            if (in_fire && (i_operation == rso_pkg::OP_COUNT) && in_lake_ok) begin
                r_counts[in_lake_sel] <= (int'(i_entry_index) > ENTRIES)
                                         ? CNT_W'(ENTRIES) : CNT_W'(i_entry_index);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_outflow <= n_outflow;
        r_lake    <= n_lake;
        r_level   <= n_level;
        r_h       <= n_h;
        r_width   <= n_width;
        r_coef    <= n_coef;
        r_base    <= n_base;
        r_sq      <= n_sq;
        r_h15     <= n_h15;
        r_acc     <= n_acc;
        r_weir    <= n_weir;
        r_pipe    <= n_pipe;
        r_n       <= n_n;
        r_k       <= n_k;
        r_ps      <= n_ps;
        r_pf      <= n_pf;
        r_num     <= n_num;
        r_den     <= n_den;
        r_d       <= n_d;
        r_up      <= n_up;
        r_prod    <= n_prod;
    end

    assign o_out_valid = r_out_valid;
    assign o_outflow   = r_outflow;

    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({mul_busy, sq_busy, div_busy}))
        else $error("more than one arithmetic unit busy");

    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rso_pkg::S_WALK) |-> (int'(r_k) < int'(r_n)))
        else $error("table walk past entry count");

    a_mul_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == rso_pkg::S_HMUL || r_state == rso_pkg::S_KMUL
                      || r_state == rso_pkg::S_WMUL || r_state == rso_pkg::S_FMUL
                      || r_state == rso_pkg::S_IMUL))
        else $error("multiplier finished outside a multiply step");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rso_pkg::S_OUT && r_out_valid && !i_out_ready)
        |=> (r_state == rso_pkg::S_OUT))
        else $error("result dropped while output beat pending");

endmodule
